@@ src/correlated_scalar_fluctuation_assert.svh @@
// ---------------------------------------------------------------------------
// Correlated scalar fluctuation assertion macros
// Shared property forms for the concurrent checks of the block.
// ---------------------------------------------------------------------------
`ifndef CORRELATED_SCALAR_FLUCTUATION_ASSERT_SVH
`define CORRELATED_SCALAR_FLUCTUATION_ASSERT_SVH

// same-cycle implication, quiet while reset is low
`define CSF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is low
`define CSF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/csf_pkg.sv @@
// ---------------------------------------------------------------------------
// Correlated scalar fluctuation package
// Number format, payload types, stage schedule and fixed-point helpers.
// ---------------------------------------------------------------------------
package csf_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int MAG_W      = PROD_W + 1;
    localparam int DIV_W      = WORD_W + FRAC_W;
    localparam int DIV_BPS    = 2;
    localparam int DIV_STAGES = DIV_W / DIV_BPS;
    localparam int ROOT_W     = (WORD_W + FRAC_W) / 2;
    localparam int SQ_W       = 2 * ROOT_W;
    localparam int SQ_REM_W   = ROOT_W + 2;
    localparam int SQ_STAGES  = ROOT_W / 2;
    localparam int FACE_W     = 17;
    localparam int CFG_IDX_W  = 3;

    // unit latencies, operands presented to result visible
    localparam int FMUL_LAT = 2;
    localparam int DIV_LAT  = DIV_STAGES + 2;
    localparam int SQ_LAT   = SQ_STAGES + 1;

    // stage schedule of the main pipeline
    localparam int S_COF  = FMUL_LAT + 1;
    localparam int S_DET  = S_COF + FMUL_LAT + 2;
    localparam int S_SING = S_DET + 1;
    localparam int S_W    = S_DET + DIV_LAT;
    localparam int S_PG   = S_W + FMUL_LAT;
    localparam int S_PH   = S_PG + FMUL_LAT;
    localparam int S_Q1   = S_PH + 1;
    localparam int S_Q5   = S_Q1 + 4;
    localparam int S_RAD  = S_Q5 + 1;
    localparam int S_ROOT = S_RAD + SQ_LAT;
    localparam int S_PK   = S_ROOT + FMUL_LAT;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam logic [WORD_W-1:0] WORD_MAX_U = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_W-1){1'b1}}});
    localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_W-1){1'b0}}});
    localparam word_t FIX_ONE  = word_t'(1 << FRAC_W);
    localparam logic [FACE_W-1:0] FACE_ONE = FACE_W'(1 << FRAC_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEAN     = 3'd0,
        CFG_VARIANCE = 3'd1,
        CFG_FLUX_X   = 3'd2,
        CFG_FLUX_Y   = 3'd3,
        CFG_FLUX_Z   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] stress_xx;
        logic signed [31:0] stress_xy;
        logic signed [31:0] stress_xz;
        logic signed [31:0] stress_yy;
        logic signed [31:0] stress_yz;
        logic signed [31:0] stress_zz;
        logic signed [31:0] vel_fluct_x;
        logic signed [31:0] vel_fluct_y;
        logic signed [31:0] vel_fluct_z;
        logic signed [31:0] raw_scalar_fluct;
    } face_req_t;

    typedef struct packed {
        logic [FACE_W-1:0] face_value;
        logic              singular_stress;
        logic              radicand_clipped;
        logic              value_clamped;
    } face_rsp_t;

    // per-request fields that ride along the pipeline
    typedef struct packed {
        word_t xx;
        word_t xy;
        word_t xz;
        word_t yy;
        word_t yz;
        word_t zz;
        word_t ux;
        word_t uy;
        word_t uz;
        word_t raw;
        word_t base;
        word_t e1;
        word_t e2;
        word_t e3;
        logic  sing;
        logic  clip;
    } carry_t;

    function automatic word_t sat_add(word_t a, word_t b);
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        return word_t'(s[WORD_W-1:0]);
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        return word_t'(s[WORD_W-1:0]);
    endfunction

    function automatic logic [WORD_W-1:0] mag(word_t a);
        logic [WORD_W-1:0] u;
        u = a;
        return a[WORD_W-1] ? (~u + 1'b1) : u;
    endfunction

    // magnitude and sign back to a word, saturating
    function automatic word_t to_word(logic [MAG_W-1:0] m, logic neg);
        logic [MAG_W-1:0]  lim;
        logic [WORD_W-1:0] lo;
        lim = {{(MAG_W-WORD_W){1'b0}}, WORD_MAX_U} + MAG_W'(neg);
        lo  = (m > lim) ? lim[WORD_W-1:0] : m[WORD_W-1:0];
        return neg ? word_t'(~lo + 1'b1) : word_t'(lo);
    endfunction

    // round a product magnitude half away from zero, drop the fraction
    function automatic word_t fix_round(logic [PROD_W-1:0] p, logic neg);
        logic [MAG_W-1:0] r;
        r = {1'b0, p} + (MAG_W'(1) << (FRAC_W - 1));
        r = r >> FRAC_W;
        return to_word(r, neg);
    endfunction

endpackage

@@ src/csf_fmul.sv @@
// ---------------------------------------------------------------------------
// Fixed-point multiplier
// Two-stage signed multiply: magnitude product, then round and saturate.
// ---------------------------------------------------------------------------
module csf_fmul (
    input  logic           clk,
    input  logic           en,
    input  csf_pkg::word_t a,
    input  csf_pkg::word_t b,
    output csf_pkg::word_t p
);
    import csf_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;
    word_t             p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(mag(a)) * PROD_W'(mag(b));
            neg_reg  <= a[WORD_W-1] ^ b[WORD_W-1];
            p_reg    <= fix_round(prod_reg, neg_reg);
        end
    end

    assign p = p_reg;

endmodule

@@ src/csf_div.sv @@
// ---------------------------------------------------------------------------
// Fixed-point divider
// Pipelined restoring division of (a << FRAC_W) by b, two quotient bits a
// stage, rounded half away from zero and saturated.
// ---------------------------------------------------------------------------
module csf_div (
    input  logic           clk,
    input  logic           en,
    input  csf_pkg::word_t num,
    input  csf_pkg::word_t den,
    output csf_pkg::word_t quo
);
    import csf_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] dvs;
        logic [DIV_W-1:0]  nq;
        logic              neg;
    } div_stage_t;

    div_stage_t s_reg [0:DIV_STAGES];
    word_t      quo_reg;
    logic [DIV_W:0] q_up;
    logic           up;

    // shift one numerator bit in, one quotient bit out
    function automatic div_stage_t div_step(div_stage_t s);
        div_stage_t      r;
        logic [WORD_W:0] trial;
        r     = s;
        trial = {s.rem, s.nq[DIV_W-1]};
        if (trial >= {1'b0, s.dvs})
        begin
            r.rem = WORD_W'(trial - {1'b0, s.dvs});
            r.nq  = {s.nq[DIV_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[WORD_W-1:0];
            r.nq  = {s.nq[DIV_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic div_stage_t div_stage(div_stage_t s);
        div_stage_t r;
        r = s;
        for (int i = 0; i < DIV_BPS; i++)
            r = div_step(r);
        return r;
    endfunction

    always_comb
    begin
        up   = {s_reg[DIV_STAGES].rem, 1'b0} >= {1'b0, s_reg[DIV_STAGES].dvs};
        q_up = {1'b0, s_reg[DIV_STAGES].nq} + (DIV_W + 1)'(up);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0].rem <= '0;
            s_reg[0].dvs <= mag(den);
            s_reg[0].nq  <= {mag(num), {FRAC_W{1'b0}}};
            s_reg[0].neg <= num[WORD_W-1] ^ den[WORD_W-1];
            for (int k = 1; k <= DIV_STAGES; k++)
                s_reg[k] <= div_stage(s_reg[k-1]);
            quo_reg <= to_word(MAG_W'(q_up), s_reg[DIV_STAGES].neg);
        end
    end

    assign quo = quo_reg;

endmodule

@@ src/csf_sqrt.sv @@
// ---------------------------------------------------------------------------
// Fixed-point square root
// Pipelined digit-by-digit floor(sqrt(a << FRAC_W)), two root bits a stage.
// ---------------------------------------------------------------------------
module csf_sqrt (
    input  logic           clk,
    input  logic           en,
    input  csf_pkg::word_t rad,
    output csf_pkg::word_t root
);
    import csf_pkg::*;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   rt;
        logic [SQ_W-1:0]     t;
    } sq_stage_t;

    sq_stage_t s_reg [0:SQ_STAGES];

    function automatic sq_stage_t sq_step(sq_stage_t s);
        sq_stage_t             r;
        logic [SQ_REM_W+1:0]   acc;
        logic [SQ_REM_W+1:0]   trial;
        r     = s;
        acc   = {s.rem, s.t[SQ_W-1 -: 2]};
        trial = (SQ_REM_W + 2)'({s.rt, 2'b01});
        if (acc >= trial)
        begin
            r.rem = SQ_REM_W'(acc - trial);
            r.rt  = {s.rt[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = SQ_REM_W'(acc);
            r.rt  = {s.rt[ROOT_W-2:0], 1'b0};
        end
        r.t = {s.t[SQ_W-3:0], 2'b00};
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0].rem <= '0;
            s_reg[0].rt  <= '0;
            s_reg[0].t   <= SQ_W'({rad, {FRAC_W{1'b0}}});
            for (int k = 1; k <= SQ_STAGES; k++)
                s_reg[k] <= sq_step(sq_step(s_reg[k-1]));
        end
    end

    assign root = word_t'({{(WORD_W-ROOT_W){1'b0}}, s_reg[SQ_STAGES].rt});

endmodule

@@ src/correlated_scalar_fluctuation.sv @@
// ---------------------------------------------------------------------------
// Correlated scalar fluctuation
// Per boundary face: w = inv(R) * flux, radicand = variance - w'Rw,
// result = clamp(mean + w.u' - sqrt(max(0, radicand)) * raw, 0, 1).
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  req     | req_valid / req_stall  | req_data   (face_req_t)
//  rsp     | rsp_valid / rsp_stall  | rsp_data   (face_rsp_t)
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One request a cycle unless a stalled result holds the pipeline.
//  Depth is set by the 48-bit divider (two quotient bits a stage) and the
//  square-root pipeline (two root bits a stage).
//  Reset clears the valid bits and the cfg registers; no memory to clear.
//  A stalled result holds the whole pipeline; an empty output slot lets it
//  run regardless of rsp_stall.
// ---------------------------------------------------------------------------
`include "correlated_scalar_fluctuation_assert.svh"

module correlated_scalar_fluctuation (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  csf_pkg::face_req_t                req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output csf_pkg::face_rsp_t                rsp_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [csf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);
    import csf_pkg::*;

    logic                adv;
    word_t               mean_reg;
    logic [WORD_W-2:0]   var_reg;
    word_t               flux_reg [3];

    logic [S_PK:0]       vld_reg;
    carry_t              carry_reg [0:S_PK];
    carry_t              carry_nx  [0:S_PK];

    word_t fa_a [12], fa_b [12], pa [12];
    word_t fc_a [12], fc_b [12], pc [12];
    word_t fg_a [9],  fg_b [9],  pg [9];
    word_t fh_a [6],  fh_b [6],  ph [6];
    word_t pk;

    word_t cof_reg [6];
    word_t d1_reg, m3_reg, det_reg;
    word_t na_reg [3], nc_reg [3], num_reg [3];
    word_t w [3];
    word_t wd1_reg [2], wd2_reg [2];
    word_t dot1_reg, wzuz_reg, dot_reg;
    word_t q_reg [5];
    word_t zq_reg;
    word_t rad_diff, rad_reg;
    word_t root;
    word_t val, res;
    logic  below, above;

    face_rsp_t rsp_next, rsp_data_reg;
    logic      rsp_valid_reg;

    // advance whenever the output slot is free or being taken
    assign adv       = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !adv;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg    <= '0;
            var_reg     <= '0;
            flux_reg[0] <= '0;
            flux_reg[1] <= '0;
            flux_reg[2] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MEAN:     mean_reg    <= cfg_data;
                CFG_VARIANCE: var_reg     <= cfg_data[WORD_W-2:0];
                CFG_FLUX_X:   flux_reg[0] <= cfg_data;
                CFG_FLUX_Y:   flux_reg[1] <= cfg_data;
                CFG_FLUX_Z:   flux_reg[2] <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[S_PK-1:0], req_valid};
            rsp_valid_reg <= vld_reg[S_PK];
        end
    end

    // carry line; late fields are dropped in where they are produced
    always_comb
    begin
        carry_nx[0]     = '0;
        carry_nx[0].xx  = req_data.stress_xx;
        carry_nx[0].xy  = req_data.stress_xy;
        carry_nx[0].xz  = req_data.stress_xz;
        carry_nx[0].yy  = req_data.stress_yy;
        carry_nx[0].yz  = req_data.stress_yz;
        carry_nx[0].zz  = req_data.stress_zz;
        carry_nx[0].ux  = req_data.vel_fluct_x;
        carry_nx[0].uy  = req_data.vel_fluct_y;
        carry_nx[0].uz  = req_data.vel_fluct_z;
        carry_nx[0].raw = req_data.raw_scalar_fluct;
        for (int k = 1; k <= S_PK; k++)
            carry_nx[k] = carry_reg[k-1];
        carry_nx[S_SING].sing = (det_reg == '0);
        carry_nx[S_Q1].base   = sat_add(mean_reg, dot_reg);
        carry_nx[S_Q1].e1     = sat_add(ph[3], ph[3]);
        carry_nx[S_Q1].e2     = sat_add(ph[4], ph[4]);
        carry_nx[S_Q1].e3     = sat_add(ph[5], ph[5]);
        carry_nx[S_RAD].clip  = rad_diff[WORD_W-1];
    end

    // cofactor products
    always_comb
    begin
        fa_a[0]  = carry_reg[0].yy; fa_b[0]  = carry_reg[0].zz;
        fa_a[1]  = carry_reg[0].yz; fa_b[1]  = carry_reg[0].yz;
        fa_a[2]  = carry_reg[0].xz; fa_b[2]  = carry_reg[0].yz;
        fa_a[3]  = carry_reg[0].xy; fa_b[3]  = carry_reg[0].zz;
        fa_a[4]  = carry_reg[0].xy; fa_b[4]  = carry_reg[0].yz;
        fa_a[5]  = carry_reg[0].xz; fa_b[5]  = carry_reg[0].yy;
        fa_a[6]  = carry_reg[0].xx; fa_b[6]  = carry_reg[0].zz;
        fa_a[7]  = carry_reg[0].xz; fa_b[7]  = carry_reg[0].xz;
        fa_a[8]  = carry_reg[0].xy; fa_b[8]  = carry_reg[0].xz;
        fa_a[9]  = carry_reg[0].xx; fa_b[9]  = carry_reg[0].yz;
        fa_a[10] = carry_reg[0].xx; fa_b[10] = carry_reg[0].yy;
        fa_a[11] = carry_reg[0].xy; fa_b[11] = carry_reg[0].xy;
    end

    // determinant terms and cofactor-flux products
    always_comb
    begin
        fc_a[0]  = carry_reg[S_COF].xx; fc_b[0]  = cof_reg[0];
        fc_a[1]  = carry_reg[S_COF].xy; fc_b[1]  = cof_reg[1];
        fc_a[2]  = carry_reg[S_COF].xz; fc_b[2]  = cof_reg[2];
        fc_a[3]  = cof_reg[0];          fc_b[3]  = flux_reg[0];
        fc_a[4]  = cof_reg[1];          fc_b[4]  = flux_reg[1];
        fc_a[5]  = cof_reg[2];          fc_b[5]  = flux_reg[2];
        fc_a[6]  = cof_reg[1];          fc_b[6]  = flux_reg[0];
        fc_a[7]  = cof_reg[3];          fc_b[7]  = flux_reg[1];
        fc_a[8]  = cof_reg[4];          fc_b[8]  = flux_reg[2];
        fc_a[9]  = cof_reg[2];          fc_b[9]  = flux_reg[0];
        fc_a[10] = cof_reg[4];          fc_b[10] = flux_reg[1];
        fc_a[11] = cof_reg[5];          fc_b[11] = flux_reg[2];
    end

    // squares, cross terms and the velocity dot product
    always_comb
    begin
        fg_a[0] = w[0];               fg_b[0] = w[0];
        fg_a[1] = w[1];               fg_b[1] = w[1];
        fg_a[2] = w[2];               fg_b[2] = w[2];
        fg_a[3] = carry_reg[S_W].xy;  fg_b[3] = w[0];
        fg_a[4] = carry_reg[S_W].xz;  fg_b[4] = w[0];
        fg_a[5] = carry_reg[S_W].yz;  fg_b[5] = w[1];
        fg_a[6] = w[0];               fg_b[6] = carry_reg[S_W].ux;
        fg_a[7] = w[1];               fg_b[7] = carry_reg[S_W].uy;
        fg_a[8] = w[2];               fg_b[8] = carry_reg[S_W].uz;
    end

    // quadratic-form terms
    always_comb
    begin
        fh_a[0] = carry_reg[S_PG].xx; fh_b[0] = pg[0];
        fh_a[1] = carry_reg[S_PG].yy; fh_b[1] = pg[1];
        fh_a[2] = carry_reg[S_PG].zz; fh_b[2] = pg[2];
        fh_a[3] = pg[3];              fh_b[3] = wd2_reg[0];
        fh_a[4] = pg[4];              fh_b[4] = wd2_reg[1];
        fh_a[5] = pg[5];              fh_b[5] = wd2_reg[1];
    end

    for (genvar g = 0; g < 12; g++)
    begin : g_mul_cof
        csf_fmul u_mul (.clk(clk), .en(adv), .a(fa_a[g]), .b(fa_b[g]), .p(pa[g]));
    end

    for (genvar g = 0; g < 12; g++)
    begin : g_mul_det
        csf_fmul u_mul (.clk(clk), .en(adv), .a(fc_a[g]), .b(fc_b[g]), .p(pc[g]));
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        csf_div u_div (.clk(clk), .en(adv), .num(num_reg[g]), .den(det_reg), .quo(w[g]));
    end

    for (genvar g = 0; g < 9; g++)
    begin : g_mul_w
        csf_fmul u_mul (.clk(clk), .en(adv), .a(fg_a[g]), .b(fg_b[g]), .p(pg[g]));
    end

    for (genvar g = 0; g < 6; g++)
    begin : g_mul_q
        csf_fmul u_mul (.clk(clk), .en(adv), .a(fh_a[g]), .b(fh_b[g]), .p(ph[g]));
    end

    csf_sqrt u_sqrt (.clk(clk), .en(adv), .rad(rad_reg), .root(root));

    csf_fmul u_mul_raw (
        .clk (clk),
        .en  (adv),
        .a   (root),
        .b   (carry_reg[S_ROOT].raw),
        .p   (pk)
    );

    assign rad_diff = sat_sub(word_t'({1'b0, var_reg}), q_reg[4]);

    // final value and clamp to [0, 1]
    always_comb
    begin
        res   = sat_sub(carry_reg[S_PK].base, pk);
        val   = carry_reg[S_PK].sing ? mean_reg : res;
        below = val[WORD_W-1];
        above = !below && (val > FIX_ONE);
        rsp_next.face_value       = below ? '0 : (above ? FACE_ONE : val[FACE_W-1:0]);
        rsp_next.singular_stress  = carry_reg[S_PK].sing;
        rsp_next.radicand_clipped = !carry_reg[S_PK].sing && carry_reg[S_PK].clip;
        rsp_next.value_clamped    = below || above;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= S_PK; k++)
                carry_reg[k] <= carry_nx[k];

            cof_reg[0] <= sat_sub(pa[0], pa[1]);
            cof_reg[1] <= sat_sub(pa[2], pa[3]);
            cof_reg[2] <= sat_sub(pa[4], pa[5]);
            cof_reg[3] <= sat_sub(pa[6], pa[7]);
            cof_reg[4] <= sat_sub(pa[8], pa[9]);
            cof_reg[5] <= sat_sub(pa[10], pa[11]);

            d1_reg <= sat_add(pc[0], pc[1]);
            m3_reg <= pc[2];
            for (int i = 0; i < 3; i++)
            begin
                na_reg[i]  <= sat_add(pc[3 + 3 * i], pc[4 + 3 * i]);
                nc_reg[i]  <= pc[5 + 3 * i];
                num_reg[i] <= sat_add(na_reg[i], nc_reg[i]);
            end
            det_reg <= sat_add(d1_reg, m3_reg);

            // hold wy and wz for the second product of the cross terms
            wd1_reg[0] <= w[1];
            wd1_reg[1] <= w[2];
            wd2_reg    <= wd1_reg;

            dot1_reg <= sat_add(pg[6], pg[7]);
            wzuz_reg <= pg[8];
            dot_reg  <= sat_add(dot1_reg, wzuz_reg);

            // accumulate the quadratic form strictly left to right
            q_reg[0] <= sat_add(ph[0], ph[1]);
            zq_reg   <= ph[2];
            q_reg[1] <= sat_add(q_reg[0], zq_reg);
            q_reg[2] <= sat_add(q_reg[1], carry_reg[S_Q1 + 1].e1);
            q_reg[3] <= sat_add(q_reg[2], carry_reg[S_Q1 + 2].e2);
            q_reg[4] <= sat_add(q_reg[3], carry_reg[S_Q1 + 3].e3);

            rad_reg <= rad_diff[WORD_W-1] ? '0 : rad_diff;

            rsp_data_reg <= rsp_next;
        end
    end

    `CSF_ASSERT_IMP(a_sing_no_clip, rsp_valid && rsp_data.singular_stress, !rsp_data.radicand_clipped, "singular result reports a clipped radicand")
    `CSF_ASSERT_IMP(a_face_range, rsp_valid, rsp_data.face_value <= FACE_ONE, "face value above one")
    `CSF_ASSERT_NXT(a_drain, !req_stall && vld_reg[S_PK], rsp_valid, "last stage did not reach the output register")

endmodule
